// ----- rtl/core/ipfr_pkg.sv -----
// shared types and constants of the ip fragment reassembly tracker
package ipfr_pkg;

   localparam int BUF_BYTES = 8192;
   localparam int MAP_DEPTH = BUF_BYTES / 64 + 1;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int LEN_W     = 14;
   localparam int ALU_W     = 17;

   localparam logic [LEN_W-1:0] BUF_LIMIT = LEN_W'(BUF_BYTES);
   localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(8192);

   typedef enum logic [1:0] {
      ST_MISMATCH = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_STORED   = 2'd2,
      ST_COMPLETE = 2'd3
   } status_type;

   typedef enum logic {
      ALU_SUB = 1'b0,
      ALU_ADD = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] value;
      logic             neg;
   } alu_rsp_type;

endpackage

// ----- rtl/core/ip_fragment_reassembly_tracker_core.sv -----
// top level of the ip fragment reassembly tracker: sequencer, coverage map and result register
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: fragment descriptor, tuser: more_frags
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: base, len, total, tuser: status
//  csr     | in  | csr_valid/csr_ready   | csr_data: buffer_limit
//
// one fragment passes through key compare, four shared-adder steps, marking of the map bytes
// it touches, a check of the map once the last fragment is known (else skipped), an output
// load and the idle state
// req_tready is high only while the sequencer is idle; a result waiting in the output
// register holds back only the next result, so the next beat can be taken while rsp stalls
// synchronous active-high reset; map valid bits clear at once, no clearing pass
module ip_fragment_reassembly_tracker_core
   import ipfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] src_addr, [63:32] dst_addr, [79:64] ident, [95:80] total_len,
   // [99:96] header_words, [112:100] frag_offset, [119:113] zero
   input  logic [119:0] req_tdata,
   // [0] more_frags
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [13:0] write_base, [27:14] write_len, [41:28] payload_total, [47:42] zero
   output logic [47:0]  rsp_tdata,
   // [1:0] status
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [13:0]  csr_data
);

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_KEY  = 11'b000_0000_0010,
      S_LEN  = 11'b000_0000_0100,
      S_END  = 11'b000_0000_1000,
      S_LIM1 = 11'b000_0001_0000,
      S_LIM2 = 11'b000_0010_0000,
      S_MARK = 11'b000_0100_0000,
      S_MWB  = 11'b000_1000_0000,
      S_CHK  = 11'b001_0000_0000,
      S_CHKW = 11'b010_0000_0000,
      S_OUT  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // captured fragment
   logic [31:0] f_src_ff, f_src_in;
   logic [31:0] f_dst_ff, f_dst_in;
   logic [15:0] f_ident_ff, f_ident_in;
   logic [15:0] f_tlen_ff, f_tlen_in;
   logic [3:0]  f_hw_ff, f_hw_in;
   logic [12:0] f_fo_ff, f_fo_in;
   logic        f_more_ff, f_more_in;

   // packet state
   logic             busy_ff, busy_in;
   logic [31:0]      key_src_ff, key_src_in;
   logic [31:0]      key_dst_ff, key_dst_in;
   logic [15:0]      key_ident_ff, key_ident_in;
   logic             last_seen_ff, last_seen_in;
   logic [LEN_W-1:0] packet_len_ff, packet_len_in;
   logic [LEN_W-1:0] limit_ff;

   // working registers
   logic [ALU_W-1:0]  len_ff, len_in;
   logic [ALU_W-1:0]  end_ff, end_in;
   logic [MAP_AW-1:0] ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic [MAP_AW-1:0] pend_addr_ff, pend_addr_in;
   logic              ok_ff, ok_in;

   // staged result and output register
   status_type       res_status_ff, res_status_in;
   logic [LEN_W-1:0] res_base_ff, res_base_in;
   logic [LEN_W-1:0] res_len_ff, res_len_in;
   logic [LEN_W-1:0] res_total_ff, res_total_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0] rsp_base_ff, rsp_base_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;
   logic [LEN_W-1:0] rsp_total_ff, rsp_total_in;

   // coverage map: one byte per 64 payload bytes, msb is the lowest 8-byte block
   logic [7:0]           map_mem [MAP_DEPTH];
   logic [MAP_DEPTH-1:0] map_valid_ff;
   logic [7:0]           rd_data_ff;
   logic                 rd_hit_ff;
   logic                 mem_we;
   logic [MAP_AW-1:0]    mem_waddr;
   logic [7:0]           mem_wdata;
   logic [MAP_AW-1:0]    mem_raddr;
   logic                 map_clear;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   ipfr_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   logic             req_fire;
   logic [LEN_W-1:0] limit_eff;
   logic             key_match;
   logic [7:0]       rd_word;
   logic [MAP_AW-1:0] first_byte;
   logic [MAP_AW-1:0] last_byte;
   logic [MAP_AW-1:0] full_byte;
   logic [7:0]       lo_mask;
   logic [7:0]       hi_mask;
   logic [7:0]       want;
   logic [7:0]       expect_word;
   logic             chk_eq;
   logic             last_next;
   logic [LEN_W-1:0] frag_base;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_total_ff, rsp_len_ff, rsp_base_ff};
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      // limit above the buffer size is held to the buffer size
      limit_eff = (limit_ff > BUF_LIMIT) ? BUF_LIMIT : limit_ff;
      key_match = (key_src_ff == f_src_ff) && (key_dst_ff == f_dst_ff) &&
                  (key_ident_ff == f_ident_ff);
      rd_word    = rd_hit_ff ? rd_data_ff : 8'h00;
      // offsets past the limit never reach the map, so these part-selects hold
      first_byte = f_fo_ff[10:3];
      last_byte  = end_ff[13:6];
      full_byte  = packet_len_ff[13:6];
      frag_base  = {f_fo_ff[10:0], 3'b000};
      // bits of the blocks inside [offset, end) for the byte being written
      lo_mask = (pend_addr_ff == first_byte) ? (8'hFF >> f_fo_ff[2:0]) : 8'hFF;
      hi_mask = (pend_addr_ff == last_byte) ? ~(8'hFF >> end_ff[5:3]) : 8'hFF;
      // the end byte must hold exactly the blocks below packet_len
      want        = ~(8'hFF >> packet_len_ff[5:3]);
      expect_word = (pend_addr_ff == full_byte) ? want : 8'hFF;
      chk_eq      = (rd_word == expect_word);
      last_next   = last_seen_ff | ~f_more_ff;
   end

   always_comb begin
      state_in      = state_ff;
      f_src_in      = f_src_ff;
      f_dst_in      = f_dst_ff;
      f_ident_in    = f_ident_ff;
      f_tlen_in     = f_tlen_ff;
      f_hw_in       = f_hw_ff;
      f_fo_in       = f_fo_ff;
      f_more_in     = f_more_ff;
      busy_in       = busy_ff;
      key_src_in    = key_src_ff;
      key_dst_in    = key_dst_ff;
      key_ident_in  = key_ident_ff;
      last_seen_in  = last_seen_ff;
      packet_len_in = packet_len_ff;
      len_in        = len_ff;
      end_in        = end_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      ok_in         = ok_ff;
      res_status_in = res_status_ff;
      res_base_in   = res_base_ff;
      res_len_in    = res_len_ff;
      res_total_in  = res_total_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_total_in  = rsp_total_ff;

      mem_we    = 1'b0;
      mem_waddr = pend_addr_ff;
      mem_wdata = rd_word | (lo_mask & hi_mask);
      mem_raddr = ptr_ff;
      map_clear = 1'b0;

      alu_req.op = ALU_SUB;
      alu_req.a  = {1'b0, f_tlen_ff};
      alu_req.b  = {11'b0, f_hw_ff, 2'b00};

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               f_src_in   = req_tdata[31:0];
               f_dst_in   = req_tdata[63:32];
               f_ident_in = req_tdata[79:64];
               f_tlen_in  = req_tdata[95:80];
               f_hw_in    = req_tdata[99:96];
               f_fo_in    = req_tdata[112:100];
               f_more_in  = req_tuser;
               state_in   = S_KEY;
            end
         end
         S_KEY: begin
            if (!busy_ff) begin
               // idle: this fragment opens a new packet
               busy_in      = 1'b1;
               key_src_in   = f_src_ff;
               key_dst_in   = f_dst_ff;
               key_ident_in = f_ident_ff;
               last_seen_in = 1'b0;
               map_clear    = 1'b1;
               state_in     = S_LEN;
            end else if (!key_match) begin
               res_status_in = ST_MISMATCH;
               res_base_in   = '0;
               res_len_in    = '0;
               res_total_in  = '0;
               state_in      = S_OUT;
            end else begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            // payload length; a header longer than the packet is an overflow
            len_in = alu_rsp.value;
            if (alu_rsp.neg) begin
               busy_in       = 1'b0;
               res_status_in = ST_OVERFLOW;
               res_base_in   = '0;
               res_len_in    = '0;
               res_total_in  = '0;
               state_in      = S_OUT;
            end else begin
               state_in = S_END;
            end
         end
         S_END: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = {1'b0, f_fo_ff, 3'b000};
            alu_req.b  = len_ff;
            end_in     = alu_rsp.value;
            state_in   = S_LIM1;
         end
         S_LIM1: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {3'b0, limit_eff};
            alu_req.b  = {1'b0, f_fo_ff, 3'b000};
            if (alu_rsp.neg) begin
               busy_in       = 1'b0;
               res_status_in = ST_OVERFLOW;
               res_base_in   = '0;
               res_len_in    = '0;
               res_total_in  = '0;
               state_in      = S_OUT;
            end else begin
               state_in = S_LIM2;
            end
         end
         S_LIM2: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {3'b0, limit_eff};
            alu_req.b  = end_ff;
            if (alu_rsp.neg) begin
               busy_in       = 1'b0;
               res_status_in = ST_OVERFLOW;
               res_base_in   = '0;
               res_len_in    = '0;
               res_total_in  = '0;
               state_in      = S_OUT;
            end else begin
               ptr_in   = first_byte;
               pend_in  = 1'b0;
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            // read byte ptr while the byte read last cycle is written back
            mem_we       = pend_ff;
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff;
            if (ptr_ff == last_byte) begin
               state_in = S_MWB;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_MWB: begin
            mem_we  = 1'b1;
            pend_in = 1'b0;
            if (!f_more_ff) begin
               last_seen_in  = 1'b1;
               packet_len_in = end_ff[LEN_W-1:0];
            end
            if (last_next) begin
               ptr_in   = '0;
               ok_in    = 1'b1;
               state_in = S_CHK;
            end else begin
               res_status_in = ST_STORED;
               res_base_in   = frag_base;
               res_len_in    = len_ff[LEN_W-1:0];
               res_total_in  = '0;
               state_in      = S_OUT;
            end
         end
         S_CHK: begin
            // bytes below the end byte must be full, the end byte exact
            if (pend_ff) begin
               ok_in = ok_ff & chk_eq;
            end
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff;
            if (ptr_ff == full_byte) begin
               state_in = S_CHKW;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_CHKW: begin
            pend_in     = 1'b0;
            res_base_in = frag_base;
            res_len_in  = len_ff[LEN_W-1:0];
            if (ok_ff & chk_eq) begin
               busy_in       = 1'b0;
               res_status_in = ST_COMPLETE;
               res_total_in  = packet_len_ff;
            end else begin
               res_status_in = ST_STORED;
               res_total_in  = '0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_base_in   = res_base_ff;
               rsp_len_in    = res_len_ff;
               rsp_total_in  = res_total_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         busy_ff       <= 1'b0;
         key_src_ff    <= '0;
         key_dst_ff    <= '0;
         key_ident_ff  <= '0;
         last_seen_ff  <= 1'b0;
         packet_len_ff <= '0;
         limit_ff      <= LIMIT_RESET;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         key_src_ff    <= key_src_in;
         key_dst_ff    <= key_dst_in;
         key_ident_ff  <= key_ident_in;
         last_seen_ff  <= last_seen_in;
         packet_len_ff <= packet_len_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      f_src_ff      <= f_src_in;
      f_dst_ff      <= f_dst_in;
      f_ident_ff    <= f_ident_in;
      f_tlen_ff     <= f_tlen_in;
      f_hw_ff       <= f_hw_in;
      f_fo_ff       <= f_fo_in;
      f_more_ff     <= f_more_in;
      len_ff        <= len_in;
      end_ff        <= end_in;
      ptr_ff        <= ptr_in;
      pend_addr_ff  <= pend_addr_in;
      ok_ff         <= ok_in;
      res_status_ff <= res_status_in;
      res_base_ff   <= res_base_in;
      res_len_ff    <= res_len_in;
      res_total_ff  <= res_total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // map memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= map_mem[mem_raddr];
   end

   // per-byte valid bits: an unwritten byte reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= '0;
         rd_hit_ff    <= 1'b0;
      end else begin
         if (map_clear) begin
            map_valid_ff <= '0;
         end else if (mem_we) begin
            map_valid_ff[mem_waddr] <= 1'b1;
         end
         rd_hit_ff <= map_valid_ff[mem_raddr] & ~map_clear;
      end
   end

endmodule

// ----- rtl/core/ipfr_alu.sv -----
// shared add/subtract unit with borrow flag for length and limit checks
module ipfr_alu
   import ipfr_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [ALU_W:0] sum;

   always_comb begin
      unique case (req.op)
         ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
         ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
         default: sum = '0;
      endcase
      rsp.value = sum[ALU_W-1:0];
      // set when a subtraction went below zero or an addition carried out
      rsp.neg   = sum[ALU_W];
   end

endmodule
